// ----- src/amc_pkg.sv -----
// Shared types, codes and fixed-point constants for the arm position mode controller.
// No dependencies; every other file imports this package.
`default_nettype none

package amc_pkg;

  localparam int POSITION_BITS  = 12;
  localparam int DUTY_BITS      = 16;
  localparam int MODE_BITS      = 3;
  localparam int STATUS_BITS    = 2;
  localparam int ROLLER_BITS    = 2;
  localparam int POWER_BITS     = 15;
  localparam int DOWN_BITS      = 16;
  localparam int TICK_BITS      = 15;
  localparam int CD_BITS        = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = (POSITION_BITS > DOWN_BITS) ? POSITION_BITS : DOWN_BITS;

  // Mode codes
  localparam logic [MODE_BITS-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_TOP    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_BOTTOM = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_MIDDLE = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_UP     = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_DOWN   = 3'd5;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_BUSY    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_SUCCESS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_TIMEOUT = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_ABORTED = 2'd3;

  // Roller command and roller power codes
  localparam logic [ROLLER_BITS-1:0] ROLLER_KEEP = 2'd0;
  localparam logic [ROLLER_BITS-1:0] ROLLER_SUCK = 2'd1;
  localparam logic [ROLLER_BITS-1:0] ROLLER_STOP = 2'd2;
  localparam logic [ROLLER_BITS-1:0] RPOW_KEEP    = 2'd0;
  localparam logic [ROLLER_BITS-1:0] RPOW_FULL    = 2'd1;
  localparam logic [ROLLER_BITS-1:0] RPOW_REDUCED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_LIMIT     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIDDLE_TARGET = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_LIMIT    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIDDLE_BAND   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UP_POWER      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_POWER    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOWN_POWER    = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_TICKS = 3'd7;

  // Fixed point. Every proportional term reduces to floor((x + 62) / 125):
  //   top    x = (high - pos) * 3*ONE/8
  //   bottom x = (pos - low)  * 3*ONE/16
  //   middle x = (|err| - band) * 5*ONE/4
  localparam longint DUTY_ONE   = longint'(1) << (DUTY_BITS - 1);
  localparam int     QX_BITS    = POSITION_BITS + DUTY_BITS;
  localparam int     QUO_BITS   = QX_BITS - 6;
  localparam int     DIV_SHIFT  = QX_BITS + 7;
  localparam int     WIDE_BITS  = QX_BITS + 2;

  localparam logic [QX_BITS:0]   DIV_RECIP  = (QX_BITS + 1)'(
      (longint'(1) << DIV_SHIFT) / 125 + 1);
  localparam logic [QX_BITS-1:0] TOP_SCALE  = QX_BITS'(3 * DUTY_ONE / 8);
  localparam logic [QX_BITS-1:0] BOT_SCALE  = QX_BITS'(3 * DUTY_ONE / 16);
  localparam logic [QX_BITS-1:0] MID_SCALE  = QX_BITS'(5 * DUTY_ONE / 4);
  localparam logic [QX_BITS-1:0] ROUND_BIAS = QX_BITS'(62);

  localparam logic signed [WIDE_BITS-1:0] DUTY_MAX_W = WIDE_BITS'(DUTY_ONE - 1);
  localparam logic signed [WIDE_BITS-1:0] DUTY_MIN_W = WIDE_BITS'(-DUTY_ONE);
  localparam logic signed [WIDE_BITS-1:0] FLOOR15_W  = WIDE_BITS'((15 * DUTY_ONE + 50) / 100);
  localparam logic signed [WIDE_BITS-1:0] LIM35_W    = WIDE_BITS'((35 * DUTY_ONE + 50) / 100);

  localparam logic signed [CD_BITS-1:0] CD_MIN     = {1'b1, {(CD_BITS-1){1'b0}}};
  localparam logic signed [CD_BITS-1:0] CD_SUCCESS = CD_BITS'(100);

  typedef struct packed {
    logic [POSITION_BITS-1:0] low_limit;
    logic [POSITION_BITS-1:0] middle_target;
    logic [POSITION_BITS-1:0] high_limit;
    logic [POSITION_BITS-1:0] middle_deadband;
    logic [POWER_BITS-1:0]    up_power;
    logic [POWER_BITS-1:0]    hold_power;
    logic signed [DOWN_BITS-1:0] down_power;
    logic [TICK_BITS-1:0]     timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]      previous_mode;
    logic signed [CD_BITS-1:0] countdown;
    logic                      pulse_parity;
  } state_t;

  typedef struct packed {
    logic signed [DUTY_BITS-1:0] duty;
    logic [STATUS_BITS-1:0]      status;
    logic [MODE_BITS-1:0]        next_mode;
    logic [ROLLER_BITS-1:0]      roller_cmd;
    logic [ROLLER_BITS-1:0]      roller_power;
  } result_t;

endpackage

`default_nettype wire

// ----- src/arm_position_mode_controller.sv -----
// Top level of the arm position mode controller: input register, datapath, result register.
// Depends on amc_pkg, amc_regs, amc_datapath (and amc_div125 below it).
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   ---------------------------------------------
// in        in_valid/in_ready    position, mode, abort
// out       out_valid/out_ready  duty, status, next_mode, roller_cmd, roller_power
// cfg       cfg_we (no stall)    cfg_index, cfg_data
//
// An input transaction goes through the input register, then the datapath, into the
// result register. Throughput is one transaction per cycle while out_ready does not
// stall the result register; the single divide-by-125 multiplier sets
// the critical path. Controller state updates as a result enters the result register.
// A stalled result holds the result register; the input register still takes one
// more transaction, and in_ready then drops until out_ready frees the stage.
// Synchronous reset clears valids and controller state and loads register defaults.

module arm_position_mode_controller import amc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [POSITION_BITS-1:0]    position,
  input  logic [MODE_BITS-1:0]        mode,
  input  logic                        abort,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DUTY_BITS-1:0] duty,
  output logic [STATUS_BITS-1:0]      status,
  output logic [MODE_BITS-1:0]        next_mode,
  output logic [ROLLER_BITS-1:0]      roller_cmd,
  output logic [ROLLER_BITS-1:0]      roller_power,
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t result;
  result_t out_item;

  // Input register
  logic                     s1_valid;
  logic [POSITION_BITS-1:0] s1_position;
  logic [MODE_BITS-1:0]     s1_mode;
  logic                     s1_abort;

  logic advance;

  // Move the held transaction into the result register when it is free or draining.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  amc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  amc_datapath u_datapath (
    .position   (s1_position),
    .mode       (s1_mode),
    .abort      (s1_abort),
    .cfg        (cfg),
    .state      (state),
    .result     (result),
    .state_next (state_next)
  );

  // Control: valids and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid            <= 1'b0;
      out_valid           <= 1'b0;
      state.previous_mode <= MODE_IDLE;
      state.countdown     <= '0;
      state.pulse_parity  <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_position <= position;
      s1_mode     <= mode;
      s1_abort    <= abort;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  assign duty         = out_item.duty;
  assign status       = out_item.status;
  assign next_mode    = out_item.next_mode;
  assign roller_cmd   = out_item.roller_cmd;
  assign roller_power = out_item.roller_power;

endmodule

`default_nettype wire

// ----- src/amc_regs.sv -----
// Configuration register file for the arm position mode controller.
// Depends on amc_pkg.
`default_nettype none

module amc_regs import amc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit       <= POSITION_BITS'(280);
      cfg.middle_target   <= POSITION_BITS'(621);
      cfg.high_limit      <= POSITION_BITS'(530);
      cfg.middle_deadband <= POSITION_BITS'(10);
      cfg.up_power        <= POWER_BITS'(9830);
      cfg.hold_power      <= POWER_BITS'(3277);
      cfg.down_power      <= -DOWN_BITS'(4915);
      cfg.timeout_ticks   <= TICK_BITS'(75);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_LIMIT:     cfg.low_limit       <= cfg_data[POSITION_BITS-1:0];
        REG_MIDDLE_TARGET: cfg.middle_target   <= cfg_data[POSITION_BITS-1:0];
        REG_HIGH_LIMIT:    cfg.high_limit      <= cfg_data[POSITION_BITS-1:0];
        REG_MIDDLE_BAND:   cfg.middle_deadband <= cfg_data[POSITION_BITS-1:0];
        REG_UP_POWER:      cfg.up_power        <= cfg_data[POWER_BITS-1:0];
        REG_HOLD_POWER:    cfg.hold_power      <= cfg_data[POWER_BITS-1:0];
        REG_DOWN_POWER:    cfg.down_power      <= signed'(cfg_data[DOWN_BITS-1:0]);
        REG_TIMEOUT_TICKS: cfg.timeout_ticks   <= cfg_data[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/amc_div125.sv -----
// Constant divider: floor(dividend / 125) by reciprocal multiplication.
// Depends on amc_pkg (DIV_RECIP, DIV_SHIFT, operand widths).
`default_nettype none

module amc_div125 import amc_pkg::*; (
  input  logic [QX_BITS-1:0]  dividend,
  output logic [QUO_BITS-1:0] quotient
);

  // Recip error times the largest dividend stays below 2^DIV_SHIFT, so the
  // truncated product is exact.
  logic [2*QX_BITS:0] product;

  assign product  = (2*QX_BITS+1)'(dividend) * (2*QX_BITS+1)'(DIV_RECIP);
  assign quotient = product[DIV_SHIFT +: QUO_BITS];

endmodule

`default_nettype wire

// ----- src/amc_datapath.sv -----
// One control tick: mode decode, countdown, proportional terms and duty saturation.
// Depends on amc_pkg and amc_div125.
`default_nettype none

module amc_datapath import amc_pkg::*; (
  input  logic [POSITION_BITS-1:0] position,
  input  logic [MODE_BITS-1:0]     mode,
  input  logic                     abort,
  input  cfg_t                     cfg,
  input  state_t                   state,
  output result_t                  result,
  output state_t                   state_next
);

  logic [POSITION_BITS-1:0]     top_diff;
  logic [POSITION_BITS-1:0]     bot_diff;
  logic signed [WIDE_BITS-1:0]  mid_err;
  logic signed [WIDE_BITS-1:0]  band_w;
  logic signed [WIDE_BITS-1:0]  mid_mag_w;
  logic [POSITION_BITS-1:0]     mid_mag;
  logic                         mid_neg;
  logic                         mid_in_band;
  logic [QX_BITS-1:0]           div_x;
  logic [QUO_BITS-1:0]          div_q;
  logic signed [WIDE_BITS-1:0]  q_w;
  logic signed [WIDE_BITS-1:0]  cap_w;
  logic signed [WIDE_BITS-1:0]  hold_w;
  logic signed [WIDE_BITS-1:0]  up_w;
  logic signed [WIDE_BITS-1:0]  dp_w;
  logic signed [CD_BITS-1:0]    cd_load;
  logic signed [CD_BITS-1:0]    cd_dec;
  logic signed [WIDE_BITS-1:0]  duty_raw;
  logic signed [DUTY_BITS-1:0]  duty_sat;
  logic [STATUS_BITS-1:0]       status;
  logic [MODE_BITS-1:0]         next_mode;
  logic [ROLLER_BITS-1:0]       rcmd;
  logic [ROLLER_BITS-1:0]       rpow;
  logic signed [CD_BITS-1:0]    cd_next;
  logic                         parity_next;

  // Errors; only used on the side of the limit where they are positive.
  assign top_diff = cfg.high_limit - position;
  assign bot_diff = position - cfg.low_limit;

  assign mid_err = signed'(WIDE_BITS'(cfg.middle_target)) - signed'(WIDE_BITS'(position));
  assign band_w  = signed'(WIDE_BITS'(cfg.middle_deadband));

  always_comb begin
    mid_mag_w   = '0;
    mid_neg     = 1'b0;
    mid_in_band = 1'b0;
    if (mid_err > band_w) begin
      mid_mag_w = mid_err - band_w;
    end else if (mid_err < -band_w) begin
      mid_mag_w = -(mid_err + band_w);
      mid_neg   = 1'b1;
    end else begin
      mid_in_band = 1'b1;
    end
  end

  assign mid_mag = mid_mag_w[POSITION_BITS-1:0];

  // One shared divide-by-125; the modes are exclusive.
  always_comb begin
    case (mode)
      MODE_TOP:    div_x = QX_BITS'(top_diff) * TOP_SCALE + ROUND_BIAS;
      MODE_BOTTOM: div_x = QX_BITS'(bot_diff) * BOT_SCALE + ROUND_BIAS;
      default:     div_x = QX_BITS'(mid_mag) * MID_SCALE + ROUND_BIAS;
    endcase
  end

  amc_div125 u_div (
    .dividend (div_x),
    .quotient (div_q)
  );

  assign q_w    = signed'(WIDE_BITS'(div_q));
  assign cap_w  = signed'(WIDE_BITS'(((POWER_BITS+2)'(cfg.up_power) * (POWER_BITS+2)'(3)) >> 1));
  assign hold_w = signed'(WIDE_BITS'(cfg.hold_power));
  assign up_w   = signed'(WIDE_BITS'(cfg.up_power));
  assign dp_w   = WIDE_BITS'(cfg.down_power);

  // Countdown reloads on a mode change, then decrements with a floor in top and bottom modes.
  assign cd_load = (mode != state.previous_mode) ? signed'(CD_BITS'(cfg.timeout_ticks))
                                                 : state.countdown;
  assign cd_dec  = (cd_load != CD_MIN) ? cd_load - CD_BITS'(1) : cd_load;

  always_comb begin
    duty_raw    = '0;
    status      = ST_BUSY;
    next_mode   = mode;
    rcmd        = ROLLER_KEEP;
    rpow        = RPOW_KEEP;
    cd_next     = cd_load;
    parity_next = state.pulse_parity;
    case (mode) inside
      MODE_TOP, MODE_BOTTOM: begin
        rpow    = RPOW_FULL;
        cd_next = cd_dec;
        if (cd_dec[CD_BITS-1]) begin
          status = ST_TIMEOUT;
        end else if (mode == MODE_TOP && position >= cfg.high_limit) begin
          status   = ST_SUCCESS;
          duty_raw = hold_w;
          cd_next  = CD_SUCCESS;
        end else if (mode == MODE_BOTTOM && position <= cfg.low_limit) begin
          status  = ST_SUCCESS;
          cd_next = CD_SUCCESS;
        end else if (mode == MODE_TOP) begin
          duty_raw = (q_w < cap_w) ? q_w : cap_w;
          if (duty_raw < FLOOR15_W) begin
            duty_raw = FLOOR15_W;
          end
          rpow        = RPOW_REDUCED;
          parity_next = ~state.pulse_parity;
          rcmd        = parity_next ? ROLLER_STOP : ROLLER_SUCK;
        end else begin
          duty_raw = (-q_w > dp_w) ? -q_w : dp_w;
        end
      end
      MODE_MIDDLE: begin
        status   = mid_in_band ? ST_SUCCESS : ST_BUSY;
        duty_raw = mid_neg ? -q_w : q_w;
        if (duty_raw > LIM35_W) begin
          duty_raw = LIM35_W;
        end
        if (duty_raw < -LIM35_W) begin
          duty_raw = -LIM35_W;
        end
      end
      MODE_UP: begin
        duty_raw  = (position < cfg.high_limit) ? up_w : '0;
        next_mode = MODE_IDLE;
      end
      MODE_DOWN: begin
        duty_raw  = (position > cfg.low_limit) ? dp_w : '0;
        next_mode = MODE_IDLE;
      end
      MODE_IDLE: status = ST_SUCCESS;
      default: ;
    endcase
  end

  always_comb begin
    if (duty_raw > DUTY_MAX_W) begin
      duty_sat = DUTY_MAX_W[DUTY_BITS-1:0];
    end else if (duty_raw < DUTY_MIN_W) begin
      duty_sat = DUTY_MIN_W[DUTY_BITS-1:0];
    end else begin
      duty_sat = duty_raw[DUTY_BITS-1:0];
    end
  end

  // Abort leaves all state untouched.
  always_comb begin
    if (abort) begin
      result.duty         = '0;
      result.status       = ST_ABORTED;
      result.next_mode    = MODE_IDLE;
      result.roller_cmd   = ROLLER_KEEP;
      result.roller_power = RPOW_KEEP;
      state_next          = state;
    end else begin
      result.duty               = duty_sat;
      result.status             = status;
      result.next_mode          = next_mode;
      result.roller_cmd         = rcmd;
      result.roller_power       = rpow;
      state_next.previous_mode  = next_mode;
      state_next.countdown      = cd_next;
      state_next.pulse_parity   = parity_next;
    end
  end

endmodule

`default_nettype wire
